[hw/rtl/scip_pkg.sv]
`default_nettype none

package scip_pkg;

  // Parser phases
  localparam logic [3:0] PH_MAGIC  = 4'd0;
  localparam logic [3:0] PH_HFLAGS = 4'd1;
  localparam logic [3:0] PH_HSIZE  = 4'd2;
  localparam logic [3:0] PH_HVER   = 4'd3;
  localparam logic [3:0] PH_TAG    = 4'd4;
  localparam logic [3:0] PH_DSEG   = 4'd5;
  localparam logic [3:0] PH_DFLAGS = 4'd6;
  localparam logic [3:0] PH_DSTART = 4'd7;
  localparam logic [3:0] PH_DLEN   = 4'd8;
  localparam logic [3:0] PH_DPAY   = 4'd9;
  localparam logic [3:0] PH_EADDR  = 4'd10;
  localparam logic [3:0] PH_EBYTE  = 4'd11;
  localparam logic [3:0] PH_CSUM   = 4'd12;
  localparam logic [3:0] PH_DRAIN  = 4'd13;

  // Record tags
  localparam logic [31:0] TAG_DATA  = 32'd1;
  localparam logic [31:0] TAG_ENTRY = 32'd2;
  localparam logic [31:0] TAG_END   = 32'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_BAD_CSUM  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [31:0] MAGIC_WORD = 32'h7f494152;
  localparam logic [7:0]  PAD_BYTE   = 8'hff;

  // Result word width in bits
  localparam int TDATA_W = 56;

  // Bytes in the field read during each phase
  function automatic logic [2:0] field_len(input logic [3:0] ph);
    logic [2:0] len;
    case (ph)
      PH_MAGIC, PH_HFLAGS, PH_HSIZE, PH_DSTART, PH_DLEN, PH_EADDR, PH_CSUM: len = 3'd4;
      PH_HVER, PH_DFLAGS: len = 3'd2;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/simple_code_image_parser.sv]
`default_nettype none

// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+--------------------------------------------
// s_       | in  | s_tvalid/s_tready | s_tdata: in_byte; s_tlast: last_byte
// m_       | out | m_tvalid/m_tready | m_tuser: kind; m_tdata: data_byte,
//          |     |                   |   block_start, block_address, status, pad_count
//
// One file byte is taken per cycle while s_tready is high; each transfer is parsed
// by a single layer of logic (a 32-bit add for the byte sum and address, a field
// shift, a compare) that feeds the result register; at most one result per byte.
// s_tready is high whenever the result register is empty or is being drained,
// so a stall on the output only holds the input once a result is waiting.
// rst (synchronous, active high) returns the parser to the magic phase and
// empties the result register; PAD_BYTE is the fill value the pad count refers to.
module simple_code_image_parser
  import scip_pkg::*;
#(
  parameter int BLOCK_BYTES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [7:0]         s_tdata,   // [7:0] in_byte
  input  wire logic               s_tlast,   // last_byte
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  output      logic [TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [8] block_start,
                                             // [40:9] block_address, [43:41] status,
                                             // [51:44] pad_count, [55:52] zero
  output      logic               m_tuser    // kind: 0 data byte, 1 final status
);

  localparam int OFF_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  // Parser state
  logic [3:0]       phase,           phase_next;
  logic [2:0]       field_count,     field_count_next;
  logic [31:0]      field_shift,     field_shift_next;
  logic [31:0]      record_left,     record_left_next;
  logic [31:0]      current_address, current_address_next;
  logic [OFF_W-1:0] block_offset,    block_offset_next;
  logic [31:0]      running_sum,     running_sum_next;
  logic             bad_tag_seen,    bad_tag_seen_next;

  // Result built this cycle
  logic               res_valid;
  logic               res_kind;
  logic [TDATA_W-1:0] res_data;

  logic s_xfer;

  // Combinational helpers
  logic [3:0]       ph;
  logic [2:0]       cnt_inc;
  logic [31:0]      val;
  logic [OFF_W:0]   off_inc;
  logic [OFF_W-1:0] off_wrap;
  logic             emit_st;
  logic [2:0]       st_code;
  logic             st_clear;
  logic             do_clear;
  logic [9:0]       pad_full;
  logic [7:0]       pad;

  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;

  always_comb begin
    phase_next           = phase;
    field_count_next     = field_count;
    field_shift_next     = field_shift;
    record_left_next     = record_left;
    current_address_next = current_address;
    block_offset_next    = block_offset;
    running_sum_next     = running_sum;
    bad_tag_seen_next    = bad_tag_seen;
    res_valid            = 1'b0;
    res_kind             = 1'b0;
    res_data             = '0;
    emit_st              = 1'b0;
    st_code              = ST_OK;
    st_clear             = 1'b0;
    do_clear             = 1'b0;
    ph                   = (phase > PH_CSUM) ? PH_MAGIC : phase;
    cnt_inc              = field_count + 3'd1;
    val                  = {field_shift[23:0], s_tdata};
    off_inc              = {1'b0, block_offset} + {{OFF_W{1'b0}}, 1'b1};
    off_wrap             = (off_inc >= (OFF_W+1)'(BLOCK_BYTES)) ? '0 : off_inc[OFF_W-1:0];
    pad_full             = '0;
    pad                  = '0;

    if (s_xfer) begin
      if (phase == PH_DRAIN) begin
        // Drop bytes until the end of the file
        do_clear = s_tlast;
      end else if (phase == PH_DPAY) begin
        running_sum_next     = running_sum + {24'd0, s_tdata};
        current_address_next = current_address + 32'd1;
        block_offset_next    = off_wrap;
        record_left_next     = record_left - 32'd1;
        if (record_left_next == 32'd0) begin
          phase_next = PH_TAG;
        end
        if (s_tlast) begin
          // A payload byte marked last: status replaces its data result
          emit_st  = 1'b1;
          st_code  = ST_TRUNC;
          st_clear = 1'b1;
        end else begin
          res_valid = 1'b1;
          res_kind  = 1'b0;
          res_data  = {12'd0, 3'd0, current_address, (block_offset == '0), s_tdata};
        end
      end else begin
        phase_next = ph;
        if (ph != PH_CSUM) begin
          running_sum_next = running_sum + {24'd0, s_tdata};
        end
        if (cnt_inc < field_len(ph)) begin
          // Field still incomplete: hold the bytes gathered so far
          field_shift_next = val;
          field_count_next = cnt_inc;
          if (s_tlast) begin
            emit_st  = 1'b1;
            st_code  = ST_TRUNC;
            st_clear = 1'b1;
          end
        end else begin
          field_shift_next = '0;
          field_count_next = '0;
          case (ph)
            PH_MAGIC: begin
              if (val != MAGIC_WORD) begin
                emit_st  = 1'b1;
                st_code  = ST_BAD_MAGIC;
                st_clear = s_tlast;
              end else begin
                phase_next = PH_HFLAGS;
              end
            end
            PH_HFLAGS: phase_next = PH_HSIZE;
            PH_HSIZE:  phase_next = PH_HVER;
            PH_HVER:   phase_next = PH_TAG;
            PH_TAG: begin
              if (val == TAG_DATA) begin
                phase_next = PH_DSEG;
              end else if (val == TAG_ENTRY) begin
                phase_next = PH_EADDR;
              end else if (val == TAG_END) begin
                phase_next = PH_CSUM;
              end else begin
                // Unknown tag: flag it and read the next byte as a tag
                bad_tag_seen_next = 1'b1;
              end
            end
            PH_DSEG:   phase_next = PH_DFLAGS;
            PH_DFLAGS: phase_next = PH_DSTART;
            PH_DSTART: begin
              current_address_next = val;
              phase_next           = PH_DLEN;
            end
            PH_DLEN: begin
              record_left_next = val;
              phase_next       = (val == 32'd0) ? PH_TAG : PH_DPAY;
            end
            PH_EADDR: phase_next = PH_EBYTE;
            PH_EBYTE: phase_next = PH_TAG;
            PH_CSUM: begin
              emit_st  = 1'b1;
              st_clear = s_tlast;
              if (val + running_sum != 32'd0) begin
                st_code = ST_BAD_CSUM;
              end else begin
                st_code = bad_tag_seen ? ST_BAD_TAG : ST_OK;
              end
            end
            default: phase_next = PH_MAGIC;
          endcase
          if (!emit_st && s_tlast) begin
            emit_st  = 1'b1;
            st_code  = ST_TRUNC;
            st_clear = 1'b1;
          end
        end
      end

      if (emit_st) begin
        // Pad count follows the block offset after this byte
        pad_full  = 10'(BLOCK_BYTES) - 10'(block_offset_next);
        pad       = (block_offset_next == '0) ? 8'd0 : pad_full[7:0];
        res_valid = 1'b1;
        res_kind  = 1'b1;
        res_data  = {4'd0, pad, st_code, 41'd0};
        if (st_clear) begin
          do_clear = 1'b1;
        end else begin
          phase_next = PH_DRAIN;
        end
      end

      if (do_clear) begin
        phase_next           = PH_MAGIC;
        field_count_next     = '0;
        field_shift_next     = '0;
        record_left_next     = '0;
        current_address_next = '0;
        block_offset_next    = '0;
        running_sum_next     = '0;
        bad_tag_seen_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      field_count     <= '0;
      field_shift     <= '0;
      record_left     <= '0;
      current_address <= '0;
      block_offset    <= '0;
      running_sum     <= '0;
      bad_tag_seen    <= 1'b0;
    end else begin
      phase           <= phase_next;
      field_count     <= field_count_next;
      field_shift     <= field_shift_next;
      record_left     <= record_left_next;
      current_address <= current_address_next;
      block_offset    <= block_offset_next;
      running_sum     <= running_sum_next;
      bad_tag_seen    <= bad_tag_seen_next;
    end
  end

  // Result register: load on a transfer that yields a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_xfer && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer && res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result register not empty after reset");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[40:0] == 41'd0 && m_tdata[55:52] == 4'd0)
    else $error("status result carries data fields");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[55:41] == 15'd0)
    else $error("data result carries status fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[43:41] <= ST_TRUNC)
    else $error("status code out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_DRAIN)
    else $error("parser phase out of range");
`endif

endmodule

`default_nettype wire
